// ===== src/bde_pkg.sv =====
package bde_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_POINTS_DEF = 64;
   localparam int MAX_DEGREE_DEF = 5;
   localparam int FRAC_BITS_DEF  = 16;

   // Field and vector widths.
   localparam int COORD_W = 32;
   localparam int VEC_W   = 3 * COORD_W;

   // Configuration register reset values and widths.
   localparam int DEGREE_W      = 3;
   localparam int POINT_COUNT_W = 7;
   localparam logic [DEGREE_W-1:0]      DEGREE_RESET      = 3'd3;
   localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RESET = 7'd4;

   // Register select taken from address bit 2.
   localparam logic REG_DEGREE      = 1'b0;
   localparam logic REG_POINT_COUNT = 1'b1;

   typedef enum logic [1:0] {
      KIND_POINT = 2'd0,
      KIND_KNOT  = 2'd1,
      KIND_EVAL  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_WRITE_OK  = 2'd0,
      STATUS_EVALUATED = 2'd1,
      STATUS_REJECTED  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_SRCH,
      ST_LDRD,
      ST_LDWR,
      ST_KA,
      ST_KB,
      ST_KC,
      ST_DIV,
      ST_WAIT,
      ST_MUL,
      ST_ACC,
      ST_WB,
      ST_FIN,
      ST_OUT,
      ST_REPLY
   } state_type;

endpackage

// ===== src/bde_ram.sv =====
module bde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bde_alpha_div.sv =====
module bde_alpha_div #(
   parameter int FRAC_BITS = bde_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [32:0]   num,
   input  logic signed [32:0]   den,
   output logic                 done,
   output logic [FRAC_BITS:0]   alpha
);

   localparam int CNTW = $clog2(FRAC_BITS + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [32:0]           rem_ff, rem_in;
   logic [32:0]           den_ff, den_in;
   logic [FRAC_BITS-1:0]  q_ff, q_in;
   logic [FRAC_BITS:0]    alpha_ff, alpha_in;

   logic [32:0] un;
   logic [32:0] ud;
   logic        neg;
   logic [33:0] rem2;
   logic [33:0] rem_sub;
   logic        ge;

   // Operand magnitudes and one restoring step.
   always_comb begin
      un      = num[32] ? 33'(-num) : 33'(num);
      ud      = den[32] ? 33'(-den) : 33'(den);
      neg     = num[32] != den[32];
      rem2    = {rem_ff, 1'b0};
      ge      = rem2 >= {1'b0, den_ff};
      rem_sub = rem2 - {1'b0, den_ff};
   end

   // Zero divisor, negative ratio and ratio of one or more finish at once;
   // otherwise one quotient bit is made per cycle.
   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      alpha_in = alpha_ff;
      if (start) begin
         if ((den == 33'sd0) || neg) begin
            alpha_in = '0;
            done_in  = 1'b1;
         end else if (un >= ud) begin
            alpha_in = (FRAC_BITS + 1)'(1) << FRAC_BITS;
            done_in  = 1'b1;
         end else begin
            run_in = 1'b1;
            rem_in = un;
            den_in = ud;
            cnt_in = CNTW'(FRAC_BITS);
            q_in   = '0;
         end
      end else if (run_ff) begin
         rem_in = ge ? rem_sub[32:0] : rem2[32:0];
         q_in   = {q_ff[FRAC_BITS-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in   = 1'b0;
            done_in  = 1'b1;
            alpha_in = {1'b0, q_in};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      alpha_ff <= alpha_in;
   end

   assign done  = done_ff;
   assign alpha = alpha_ff;

endmodule

// ===== src/bspline_de_boor_evaluator_unit.sv =====
// A write of a point or a knot goes from acceptance through the reply state to the
// result register, which takes it once the output is free. An evaluation runs a
// knot span search of S steps (one knot memory read each, at most
// point_count - p - 1), loads the points and blends them; the serial alpha divider
// sets the bulk of its time. One transaction is in work at a time.
// Reset is synchronous: it clears control state and sets degree 3, 4 points.
module bspline_de_boor_evaluator_unit #(
   parameter int MAX_POINTS = bde_pkg::MAX_POINTS_DEF,
   parameter int MAX_DEGREE = bde_pkg::MAX_DEGREE_DEF,
   parameter int FRAC_BITS  = bde_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_kind,
   input  logic [6:0]   req_index,
   input  logic [31:0]  req_value_x,
   input  logic [31:0]  req_value_y,
   input  logic [31:0]  req_value_z,
   input  logic [31:0]  req_knot_time,
   input  logic [31:0]  req_eval_time,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_pos_x,
   output logic [31:0]  rsp_pos_y,
   output logic [31:0]  rsp_pos_z,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int CW_ = bde_pkg::COORD_W;
   localparam int VW  = bde_pkg::VEC_W;
   localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
   localparam int KAW = $clog2(KNOT_DEPTH);
   localparam int PAW = $clog2(MAX_POINTS);
   localparam int DAW = $clog2(MAX_DEGREE + 1);
   localparam int KC  = $clog2(KNOT_DEPTH + 1) + 1;
   localparam int CW  = (KC > 8) ? KC : 8;
   localparam int PRW = 33 + FRAC_BITS + 1;

   // Configuration registers.
   logic [bde_pkg::DEGREE_W-1:0]      degree_ff;
   logic [bde_pkg::POINT_COUNT_W-1:0] point_count_ff;
   logic cfg_write;

   // Control and datapath registers.
   bde_pkg::state_type  state_ff, state_in;
   logic signed [31:0]  t_ff, t_in;
   logic signed [31:0]  lo_ff, lo_in;
   logic signed [31:0]  ka_ff, ka_in;
   logic signed [31:0]  kb_ff, kb_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [DAW-1:0]      j_ff, j_in;
   logic [DAW-1:0]      r_ff, r_in;
   logic [DAW-1:0]      i_ff, i_in;
   logic [1:0]          c_ff, c_in;
   logic [VW-1:0]       cur_ff, cur_in;
   logic [VW-1:0]       prev_ff, prev_in;
   logic [VW-1:0]       newd_ff, newd_in;
   logic [PRW-1:0]      prod_ff, prod_in;
   logic                pneg_ff, pneg_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [VW-1:0]       res_pos_ff, res_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [VW-1:0]       rsp_pos_ff, rsp_pos_in;

   // Memory ports.
   logic             knot_we;
   logic [KAW-1:0]   knot_waddr, knot_raddr;
   logic [31:0]      knot_rdata;
   logic             point_we;
   logic [PAW-1:0]   point_waddr, point_raddr;
   logic [VW-1:0]    point_rdata;
   logic             d_we;
   logic [DAW-1:0]   d_waddr, d_raddr;
   logic [VW-1:0]    d_wdata, d_rdata;

   // Divider.
   logic                div_start;
   logic signed [32:0]  div_num, div_den;
   logic                div_done;
   logic [FRAC_BITS:0]  div_alpha;

   // Derived sizes and decisions.
   logic [CW-1:0]  pc_w, n_w, p_w, m_w, idx_w, k_next;
   logic [DAW-1:0] p_d;
   logic           accept, out_free, point_ok, knot_ok;
   logic signed [31:0] knot_rd_s, t_lo, t_clamp;
   logic           srch_more;
   logic signed [32:0] diff;
   logic [32:0]    mag;
   logic [33:0]    rnd;
   logic signed [33:0] prev_x, blend_val;

   // Effective degree and point count clamp the register values.
   always_comb begin
      pc_w = CW'(point_count_ff);
      if (pc_w < CW'(2)) begin
         n_w = CW'(2);
      end else if (pc_w > CW'(MAX_POINTS)) begin
         n_w = CW'(MAX_POINTS);
      end else begin
         n_w = pc_w;
      end
      if (degree_ff == '0) begin
         p_w = CW'(1);
      end else if (CW'(degree_ff) > CW'(MAX_DEGREE)) begin
         p_w = CW'(MAX_DEGREE);
      end else begin
         p_w = CW'(degree_ff);
      end
      p_d      = DAW'(p_w);
      m_w      = n_w + p_w;
      idx_w    = CW'(req_index);
      accept   = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      point_ok = idx_w < n_w;
      knot_ok  = idx_w <= m_w;
      knot_rd_s = $signed(knot_rdata);
      k_next   = k_ff + CW'(1);
      srch_more = knot_rd_s < t_ff;
      t_lo     = (t_ff < lo_ff) ? lo_ff : t_ff;
      t_clamp  = (t_lo > knot_rd_s) ? knot_rd_s : t_lo;
   end

   // Blend arithmetic on the selected coordinate.
   always_comb begin
      diff = 33'(signed'(cur_ff[c_ff*CW_ +: CW_])) - 33'(signed'(prev_ff[c_ff*CW_ +: CW_]));
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      rnd  = 34'((prod_ff + (PRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      prev_x = 34'(signed'(prev_ff[c_ff*CW_ +: CW_]));
      blend_val = pneg_ff ? (prev_x - signed'(rnd)) : (prev_x + signed'(rnd));
      div_num = 33'(t_ff) - 33'(ka_ff);
      div_den = 33'(kb_ff) - 33'(ka_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bde_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_kind == bde_pkg::KIND_EVAL) && (n_w > p_w)) begin
                  state_in = bde_pkg::ST_LO;
               end else begin
                  state_in = bde_pkg::ST_REPLY;
               end
            end
         end
         bde_pkg::ST_LO:   state_in = bde_pkg::ST_HI;
         bde_pkg::ST_HI: begin
            state_in = (p_w < n_w - CW'(1)) ? bde_pkg::ST_SRCH : bde_pkg::ST_LDRD;
         end
         bde_pkg::ST_SRCH: begin
            if (!(srch_more && (k_next < n_w - CW'(1)))) begin
               state_in = bde_pkg::ST_LDRD;
            end
         end
         bde_pkg::ST_LDRD: state_in = bde_pkg::ST_LDWR;
         bde_pkg::ST_LDWR: begin
            state_in = (j_ff == p_d) ? bde_pkg::ST_KA : bde_pkg::ST_LDRD;
         end
         bde_pkg::ST_KA:   state_in = bde_pkg::ST_KB;
         bde_pkg::ST_KB:   state_in = bde_pkg::ST_KC;
         bde_pkg::ST_KC:   state_in = bde_pkg::ST_DIV;
         bde_pkg::ST_DIV:  state_in = bde_pkg::ST_WAIT;
         bde_pkg::ST_WAIT: begin
            if (div_done) begin
               state_in = bde_pkg::ST_MUL;
            end
         end
         bde_pkg::ST_MUL:  state_in = bde_pkg::ST_ACC;
         bde_pkg::ST_ACC: begin
            state_in = (c_ff == 2'd2) ? bde_pkg::ST_WB : bde_pkg::ST_MUL;
         end
         bde_pkg::ST_WB: begin
            if ((i_ff == r_ff) && (r_ff == p_d)) begin
               state_in = bde_pkg::ST_FIN;
            end else begin
               state_in = bde_pkg::ST_KA;
            end
         end
         bde_pkg::ST_FIN:  state_in = bde_pkg::ST_OUT;
         bde_pkg::ST_OUT:  state_in = bde_pkg::ST_REPLY;
         bde_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = bde_pkg::ST_IDLE;
            end
         end
         default: state_in = bde_pkg::ST_IDLE;
      endcase
   end

   // Memory controls and divider start per state.
   always_comb begin
      knot_we     = 1'b0;
      knot_waddr  = KAW'(req_index);
      knot_raddr  = '0;
      point_we    = 1'b0;
      point_waddr = PAW'(req_index);
      point_raddr = '0;
      d_we        = 1'b0;
      d_waddr     = '0;
      d_wdata     = newd_ff;
      d_raddr     = '0;
      div_start   = 1'b0;
      unique case (state_ff)
         bde_pkg::ST_IDLE: begin
            point_we   = accept && (req_kind == bde_pkg::KIND_POINT) && point_ok;
            knot_we    = accept && (req_kind == bde_pkg::KIND_KNOT) && knot_ok;
            knot_raddr = p_w[KAW-1:0];
         end
         bde_pkg::ST_LO: knot_raddr = KAW'(m_w - p_w);
         bde_pkg::ST_HI: knot_raddr = KAW'(p_w + CW'(1));
         bde_pkg::ST_SRCH: knot_raddr = KAW'(k_ff + CW'(2));
         bde_pkg::ST_LDRD: point_raddr = PAW'(k_ff - p_w + CW'(j_ff));
         bde_pkg::ST_LDWR: begin
            d_we    = 1'b1;
            d_waddr = j_ff;
            d_wdata = point_rdata;
         end
         bde_pkg::ST_KA: knot_raddr = KAW'(CW'(i_ff) + k_ff - p_w);
         bde_pkg::ST_KB: begin
            knot_raddr = KAW'(CW'(i_ff) + CW'(1) + k_ff - CW'(r_ff));
            d_raddr    = i_ff;
         end
         bde_pkg::ST_KC: d_raddr = i_ff - DAW'(1);
         bde_pkg::ST_DIV: div_start = 1'b1;
         bde_pkg::ST_WB: begin
            d_we    = 1'b1;
            d_waddr = i_ff;
         end
         bde_pkg::ST_FIN: d_raddr = p_d;
         default: begin
         end
      endcase
   end

   // Datapath register next values.
   always_comb begin
      t_in          = t_ff;
      lo_in         = lo_ff;
      ka_in         = ka_ff;
      kb_in         = kb_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      i_in          = i_ff;
      c_in          = c_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      newd_in       = newd_ff;
      prod_in       = prod_ff;
      pneg_in       = pneg_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      case (state_ff)
         bde_pkg::ST_IDLE: begin
            t_in          = $signed(req_eval_time);
            res_pos_in    = '0;
            res_status_in = bde_pkg::STATUS_REJECTED;
            case (req_kind)
               bde_pkg::KIND_POINT: begin
                  if (point_ok) begin
                     res_status_in = bde_pkg::STATUS_WRITE_OK;
                  end
               end
               bde_pkg::KIND_KNOT: begin
                  if (knot_ok) begin
                     res_status_in = bde_pkg::STATUS_WRITE_OK;
                  end
               end
               default: begin
               end
            endcase
         end
         bde_pkg::ST_LO: lo_in = knot_rd_s;
         bde_pkg::ST_HI: begin
            t_in = t_clamp;
            k_in = p_w;
            j_in = '0;
         end
         bde_pkg::ST_SRCH: begin
            if (srch_more) begin
               k_in = k_next;
            end
         end
         bde_pkg::ST_LDWR: begin
            j_in = j_ff + DAW'(1);
            r_in = DAW'(1);
            i_in = p_d;
         end
         bde_pkg::ST_KB: ka_in = knot_rd_s;
         bde_pkg::ST_KC: begin
            kb_in  = knot_rd_s;
            cur_in = d_rdata;
         end
         bde_pkg::ST_DIV: begin
            prev_in = d_rdata;
            c_in    = '0;
         end
         bde_pkg::ST_MUL: begin
            prod_in = PRW'(mag) * PRW'(div_alpha);
            pneg_in = diff[32];
         end
         bde_pkg::ST_ACC: begin
            newd_in[c_ff*CW_ +: CW_] = blend_val[31:0];
            c_in = c_ff + 2'd1;
         end
         bde_pkg::ST_WB: begin
            if (i_ff > r_ff) begin
               i_in = i_ff - DAW'(1);
            end else begin
               r_in = r_ff + DAW'(1);
               i_in = p_d;
            end
         end
         bde_pkg::ST_OUT: begin
            res_pos_in    = d_rdata;
            res_status_in = bde_pkg::STATUS_EVALUATED;
         end
         default: begin
         end
      endcase
   end

   // Result register: it takes a new transaction once the old one is gone.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if ((state_ff == bde_pkg::ST_REPLY) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
      end
   end

   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bde_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         degree_ff      <= bde_pkg::DEGREE_RESET;
         point_count_ff <= bde_pkg::POINT_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            unique case (paddr[2])
               bde_pkg::REG_DEGREE:      degree_ff <= pwdata[bde_pkg::DEGREE_W-1:0];
               bde_pkg::REG_POINT_COUNT: point_count_ff <= pwdata[bde_pkg::POINT_COUNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      t_ff          <= t_in;
      lo_ff         <= lo_in;
      ka_ff         <= ka_in;
      kb_ff         <= kb_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      i_ff          <= i_in;
      c_ff          <= c_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      newd_ff       <= newd_in;
      prod_ff       <= prod_in;
      pneg_ff       <= pneg_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   // Register read-back.
   always_comb begin
      unique case (paddr[2])
         bde_pkg::REG_DEGREE:      prdata = 32'(degree_ff);
         bde_pkg::REG_POINT_COUNT: prdata = 32'(point_count_ff);
         default:                  prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign req_stall = state_ff != bde_pkg::ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_pos_x  = rsp_pos_ff[0*CW_ +: CW_];
   assign rsp_pos_y  = rsp_pos_ff[1*CW_ +: CW_];
   assign rsp_pos_z  = rsp_pos_ff[2*CW_ +: CW_];

   // Knot, control point and working point memories.
   bde_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knot_ram (
      .clock (clock),
      .we    (knot_we),
      .waddr (knot_waddr),
      .wdata (req_knot_time),
      .raddr (knot_raddr),
      .rdata (knot_rdata)
   );

   bde_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock (clock),
      .we    (point_we),
      .waddr (point_waddr),
      .wdata ({req_value_z, req_value_y, req_value_x}),
      .raddr (point_raddr),
      .rdata (point_rdata)
   );

   bde_ram #(.WIDTH(VW), .DEPTH(MAX_DEGREE + 1)) u_work_ram (
      .clock (clock),
      .we    (d_we),
      .waddr (d_waddr),
      .wdata (d_wdata),
      .raddr (d_raddr),
      .rdata (d_rdata)
   );

   bde_alpha_div #(.FRAC_BITS(FRAC_BITS)) u_alpha_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .alpha (div_alpha)
   );

   // A new result is only loaded from the reply state.
   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bde_pkg::ST_REPLY))
      else $error("result raised outside the reply state");

   // Only an evaluated point carries nonzero coordinates.
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bde_pkg::STATUS_EVALUATED)) |->
      (rsp_pos_ff == '0))
      else $error("nonzero coordinates on a non-evaluation result");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == bde_pkg::ST_WAIT))
      else $error("divider finished outside the wait state");

endmodule
